/* rtl/core/cfd_pkg.sv */
// ----------------------------------------------------------------------------
// cfd_pkg: shared types and constants of the command frame deframer
// Frame marker bytes, event codes, queue depth and the classified byte type.
// ----------------------------------------------------------------------------
`default_nettype none
package cfd_pkg;

  localparam logic [7:0] HEAD_LO = 8'h5A;
  localparam logic [7:0] HEAD_HI = 8'h54;
  localparam logic [7:0] TAIL_LO = 8'h5A;
  localparam logic [7:0] TAIL_HI = 8'hFE;

  localparam logic [7:0] SENDER_RESET  = 8'h14;
  localparam logic [7:0] ADDRESS_RESET = 8'h1C;

  // Event codes of a result transfer.
  localparam logic [1:0] EV_START   = 2'd0;
  localparam logic [1:0] EV_PAYLOAD = 2'd1;
  localparam logic [1:0] EV_GOOD    = 2'd2;
  localparam logic [1:0] EV_REJECT  = 2'd3;

  // Register indexes of the configuration port.
  localparam logic REG_SENDER  = 1'b0;
  localparam logic REG_ADDRESS = 1'b1;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // A received byte together with the comparisons the back end needs.
  typedef struct packed {
    logic [7:0] data;
    logic       is_head_lo;
    logic       is_head_hi;
    logic       is_tail_hi;
    logic       is_sender;
    logic       is_address;
    logic       is_zero;
  } cfd_item_t;

endpackage
`default_nettype wire

/* rtl/core/cfd_front.sv */
// ----------------------------------------------------------------------------
// cfd_front: input classifier
// Accepts received bytes and tags each with its marker and id comparisons.
// ----------------------------------------------------------------------------
`default_nettype none
module cfd_front
  import cfd_pkg::*;
(
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] expected_sender,
  input  wire logic [7:0] own_address,
  input  wire logic       queue_full,
  output logic            push,
  output cfd_item_t       item
);

  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    item.data       = rx_byte;
    item.is_head_lo = (rx_byte == HEAD_LO);
    item.is_head_hi = (rx_byte == HEAD_HI);
    item.is_tail_hi = (rx_byte == TAIL_HI);
    item.is_sender  = (rx_byte == expected_sender);
    item.is_address = (rx_byte == own_address);
    item.is_zero    = (rx_byte == 8'd0);
  end

endmodule
`default_nettype wire

/* rtl/core/cfd_queue.sv */
// ----------------------------------------------------------------------------
// cfd_queue: short queue between front and back end
// A small circular buffer of classified bytes with a fill count.
// ----------------------------------------------------------------------------
`default_nettype none
module cfd_queue
  import cfd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire cfd_item_t push_item,
  input  wire logic      pop,
  output cfd_item_t      head_item,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cfd_item_t        entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign head_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/cfd_back.sv */
// ----------------------------------------------------------------------------
// cfd_back: frame state machine and result register
// Walks the frame layout one byte at a time and registers the events.
// ----------------------------------------------------------------------------
`default_nettype none
module cfd_back
  import cfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfd_item_t  head_item,
  input  wire logic       empty,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      event_res,
  output logic [7:0]      command,
  output logic [7:0]      payload_byte,
  output logic [7:0]      payload_length
);

  localparam logic [3:0] PH_HUNT   = 4'd0;
  localparam logic [3:0] PH_HEAD2  = 4'd1;
  localparam logic [3:0] PH_SENDER = 4'd2;
  localparam logic [3:0] PH_RECV   = 4'd3;
  localparam logic [3:0] PH_CMD    = 4'd4;
  localparam logic [3:0] PH_LEN    = 4'd5;
  localparam logic [3:0] PH_PAY    = 4'd6;
  localparam logic [3:0] PH_SUM    = 4'd7;
  localparam logic [3:0] PH_TAIL1  = 4'd8;
  localparam logic [3:0] PH_TAIL2  = 4'd9;

  logic [3:0] phase, phase_next;
  logic [7:0] frame_command, frame_command_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] bytes_taken, bytes_taken_next;
  logic [7:0] running_sum, running_sum_next;
  logic       emit;
  logic [1:0] emit_event;
  logic [7:0] emit_payload;
  logic [3:0] rehunt;
  logic [7:0] taken_inc;

  // The output register frees up in the same cycle its transfer completes.
  assign pop       = !empty && (!out_valid || out_ready);
  assign rehunt    = head_item.is_head_lo ? PH_HEAD2 : PH_HUNT;
  assign taken_inc = bytes_taken + 8'd1;

  always_comb begin
    phase_next         = phase;
    frame_command_next = frame_command;
    frame_length_next  = frame_length;
    bytes_taken_next   = bytes_taken;
    running_sum_next   = running_sum;
    emit               = 1'b0;
    emit_event         = EV_START;
    emit_payload       = 8'd0;
    case (phase)
      PH_HEAD2: begin
        phase_next = head_item.is_head_hi ? PH_SENDER : rehunt;
      end
      PH_SENDER: begin
        phase_next = head_item.is_sender ? PH_RECV : rehunt;
      end
      PH_RECV: begin
        phase_next = head_item.is_address ? PH_CMD : rehunt;
      end
      PH_CMD: begin
        frame_command_next = head_item.data;
        phase_next         = PH_LEN;
      end
      PH_LEN: begin
        frame_length_next = head_item.data;
        bytes_taken_next  = 8'd0;
        running_sum_next  = 8'd0;
        phase_next        = head_item.is_zero ? PH_SUM : PH_PAY;
        emit              = 1'b1;
        emit_event        = EV_START;
      end
      PH_PAY: begin
        running_sum_next = running_sum + head_item.data;
        bytes_taken_next = taken_inc;
        if (taken_inc == frame_length) begin
          phase_next = PH_SUM;
        end
        emit         = 1'b1;
        emit_event   = EV_PAYLOAD;
        emit_payload = head_item.data;
      end
      PH_SUM: begin
        if (head_item.data == running_sum) begin
          phase_next = PH_TAIL1;
        end else begin
          phase_next = rehunt;
          emit       = 1'b1;
          emit_event = EV_REJECT;
        end
      end
      PH_TAIL1: begin
        if (head_item.data == TAIL_LO) begin
          phase_next = PH_TAIL2;
        end else begin
          phase_next = rehunt;
          emit       = 1'b1;
          emit_event = EV_REJECT;
        end
      end
      PH_TAIL2: begin
        emit = 1'b1;
        if (head_item.is_tail_hi) begin
          phase_next = PH_HUNT;
          emit_event = EV_GOOD;
        end else begin
          phase_next = rehunt;
          emit_event = EV_REJECT;
        end
      end
      default: begin
        phase_next = rehunt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      frame_command <= 8'd0;
      frame_length  <= 8'd0;
      bytes_taken   <= 8'd0;
      running_sum   <= 8'd0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        phase         <= phase_next;
        frame_command <= frame_command_next;
        frame_length  <= frame_length_next;
        bytes_taken   <= bytes_taken_next;
        running_sum   <= running_sum_next;
        out_valid     <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      event_res      <= emit_event;
      command        <= frame_command_next;
      payload_byte   <= emit_payload;
      payload_length <= frame_length_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/command_frame_deframer.sv */
// ----------------------------------------------------------------------------
// command_frame_deframer: byte stream deframer with additive checksum
// Finds 5A 54 / sender / receiver / command / length / payload / sum / 5A FE
// frames and reports frame start, payload bytes and the frame verdict.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle while in_ready is high. A byte
// is classified on entry and written into a queue of QUEUE_DEPTH entries; the
// frame state machine takes one byte from the queue per cycle whenever its
// result register is free or being emptied, and a steady stream then runs at
// one byte per cycle while the output does not stall. Bytes that cause no
// result (header, ids, command, a good sum, the first tail byte) still pass
// through the state machine in turn. When the output side stalls, the queue
// absorbs up to QUEUE_DEPTH bytes before in_ready drops.
// The sender and receiver ids sit at APB byte addresses 0 and 4 and must only
// be written while no byte is waiting in the queue or being transferred in.
`default_nettype none
module command_frame_deframer
  import cfd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       event_res,
  output logic [7:0]       command,
  output logic [7:0]       payload_byte,
  output logic [7:0]       payload_length
);

  logic [7:0] expected_sender;
  logic [7:0] own_address;
  logic       push;
  logic       pop;
  logic       queue_full;
  logic       queue_empty;
  cfd_item_t  push_item;
  cfd_item_t  head_item;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_sender <= SENDER_RESET;
      own_address     <= ADDRESS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_SENDER) begin
        expected_sender <= pwdata[7:0];
      end else begin
        own_address <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_ADDRESS) begin
      prdata = {24'd0, own_address};
    end else begin
      prdata = {24'd0, expected_sender};
    end
  end

  cfd_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .rx_byte         (rx_byte),
    .expected_sender (expected_sender),
    .own_address     (own_address),
    .queue_full      (queue_full),
    .push            (push),
    .item            (push_item)
  );

  cfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  cfd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_item      (head_item),
    .empty          (queue_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_res      (event_res),
    .command        (command),
    .payload_byte   (payload_byte),
    .payload_length (payload_length)
  );

endmodule
`default_nettype wire

/* rtl/core/cfd_checker.sv */
// ----------------------------------------------------------------------------
// cfd_checker: port-level checks of the command frame deframer
// Watches the top-level ports and is bound to every deframer instance.
// ----------------------------------------------------------------------------
`default_nettype none
module cfd_checker
  import cfd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       pready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] event_res,
  input wire logic [7:0] command,
  input wire logic [7:0] payload_byte,
  input wire logic [7:0] payload_length
);

  // A stalled result keeps its contents until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(command)
      && $stable(payload_byte) && $stable(payload_length))
    else $error("result changed while stalled");

  // Only payload events carry a nonzero payload byte.
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res != EV_PAYLOAD) |-> payload_byte == 8'd0)
    else $error("payload byte set on a non-payload event");

  // No result is left pending across a reset.
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind command_frame_deframer cfd_checker u_cfd_checker (
  .clk            (clk),
  .rst            (rst),
  .pready         (pready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .event_res      (event_res),
  .command        (command),
  .payload_byte   (payload_byte),
  .payload_length (payload_length)
);
`default_nettype wire
